>>> sv/fdmo_pkg.sv
package fdmo_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int THR_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int MIN_DIM = 3;
  localparam int WIN_N   = 3;

  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST    = CFG_W'(1280);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST   = CFG_W'(720);
  localparam logic [THR_W-1:0] DIFF_THRESHOLD_RST = THR_W'(32);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_DIFF_THRESHOLD
  } cfg_idx_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] cur_pixel;
    logic [PIX_W-1:0] prev_pixel;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] diff_value;
    logic             diff_valid;
    logic             opened_bit;
    logic             opened_valid;
    logic             opened_last;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] diff_value;
    logic             diff_valid;
    logic             eint;
    logic             eadv;
    logic [COL_W-1:0] ecol;
    logic             emit;
    logic             oint;
    logic             last;
  } stage_t;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
    int val;
    val = int'(v);
    if (val < MIN_DIM) return MIN_DIM;
    if (val > hi) return hi;
    return val;
  endfunction

endpackage

>>> sv/fdmo_cell.sv
module fdmo_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [fdmo_pkg::WIN_N-1:0] d,
  output logic [fdmo_pkg::WIN_N-1:0] q
);
  import fdmo_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

>>> sv/fdmo_window.sv
module fdmo_window (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [fdmo_pkg::COL_W-1:0]        col,
  input  logic                              bit_in,
  output logic [fdmo_pkg::WIN_N*fdmo_pkg::WIN_N-1:0] win
);
  import fdmo_pkg::*;

  // two previous rows per column: [0] one row up, [1] two rows up
  logic [WIN_N-2:0] line_mem [MAX_WIDTH];
  logic [WIN_N-2:0] rd;
  logic             adv_q;
  logic [COL_W-1:0] col_q;
  logic [WIN_N-1:0] cq [WIN_N];
  logic [WIN_N-1:0] cd [WIN_N];

  always_ff @(posedge clk) begin
    rd    <= line_mem[col];
    col_q <= col;
    if (adv_q) begin
      line_mem[col_q] <= {rd[0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_q <= 1'b0;
    end else begin
      adv_q <= adv;
    end
  end

  for (genvar i = 0; i < WIN_N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cd[i] = {rd, bit_in};
    end else begin : g_link
      assign cd[i] = cq[i-1];
    end
    fdmo_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv_q),
      .d   (cd[i]),
      .q   (cq[i])
    );
    assign win[i*WIN_N +: WIN_N] = cq[i];
  end

endmodule

>>> sv/fdmo_ctrl.sv
module fdmo_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fdmo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdmo_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           accept,
  input  fdmo_pkg::req_t                 req_word,
  output logic                           win_adv,
  output logic [fdmo_pkg::COL_W-1:0]     win_col,
  output logic [fdmo_pkg::THR_W-1:0]     thr,
  output fdmo_pkg::stage_t               s1
);
  import fdmo_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [THR_W-1:0] diff_threshold;

  logic [HGT_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [WID_W-1:0] geo_w, geo_w_next;
  logic [HGT_W-1:0] geo_h, geo_h_next;

  logic             is_flush, done, pix, first, emit, eint, oint, last;
  logic [COL_W-1:0] ecol;
  logic [PIX_W-1:0] diff;
  stage_t           s1_next;

  always_comb begin
    is_flush = (req_word.req_type == REQ_FLUSH);
    done     = (in_row >= geo_h);
    pix      = !is_flush && !done;
    first    = pix && (in_row == '0) && (in_col == '0);

    geo_w_next = first ? WID_W'(clamp_dim(frame_width, MAX_WIDTH)) : geo_w;
    geo_h_next = first ? HGT_W'(clamp_dim(frame_height, MAX_HEIGHT)) : geo_h;

    // opened output lags input by 2*width+2 positions
    emit = done || (pix && ((int'(in_row) >= 3) ||
                            ((int'(in_row) == 2) && (int'(in_col) >= 2))));
    eint = pix && (int'(in_row) >= 2) && (int'(in_col) >= 2);

    // column of the eroded stream position handled by this word
    if (done) begin
      ecol = (int'(out_col) + 1 >= int'(geo_w)) ? '0 : out_col + 1'b1;
    end else begin
      ecol = (in_col == '0) ? COL_W'(geo_w_next - 1'b1) : in_col - 1'b1;
    end

    oint = (out_row != '0) && (int'(out_row) + 2 <= int'(geo_h_next)) &&
           (out_col != '0) && (int'(out_col) + 2 <= int'(geo_w_next));
    last = (int'(out_row) + 1 == int'(geo_h_next)) &&
           (int'(out_col) + 1 == int'(geo_w_next));

    if (is_flush) begin
      diff = '0;
    end else if (req_word.cur_pixel >= req_word.prev_pixel) begin
      diff = req_word.cur_pixel - req_word.prev_pixel;
    end else begin
      diff = req_word.prev_pixel - req_word.cur_pixel;
    end

    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (pix) begin
      if (int'(in_col) + 1 >= int'(geo_w_next)) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end
    if (emit) begin
      if (last) begin
        in_row_next  = '0;
        in_col_next  = '0;
        out_row_next = '0;
        out_col_next = '0;
      end else if (int'(out_col) + 1 >= int'(geo_w_next)) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end

    s1_next.valid      = accept;
    s1_next.diff_value = diff;
    s1_next.diff_valid = !is_flush;
    s1_next.eint       = eint;
    s1_next.eadv       = pix || done;
    s1_next.ecol       = ecol;
    s1_next.emit       = emit;
    s1_next.oint       = oint;
    s1_next.last       = last;

    win_adv = accept && pix;
    win_col = in_col;
    thr     = diff_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1             <= '0;
      in_row         <= '0;
      in_col         <= '0;
      out_row        <= '0;
      out_col        <= '0;
      geo_w          <= WID_W'(MIN_DIM);
      geo_h          <= HGT_W'(MIN_DIM);
      frame_width    <= FRAME_WIDTH_RST;
      frame_height   <= FRAME_HEIGHT_RST;
      diff_threshold <= DIFF_THRESHOLD_RST;
    end else begin
      s1 <= s1_next;
      if (accept) begin
        in_row  <= in_row_next;
        in_col  <= in_col_next;
        out_row <= out_row_next;
        out_col <= out_col_next;
        geo_w   <= geo_w_next;
        geo_h   <= geo_h_next;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:    frame_width    <= cfg_data;
          CFG_FRAME_HEIGHT:   frame_height   <= cfg_data;
          CFG_DIFF_THRESHOLD: diff_threshold <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/fdmo_ofifo.sv
module fdmo_ofifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  fdmo_pkg::rsp_t                   push_word,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output fdmo_pkg::rsp_t                   rsp_word,
  output logic [fdmo_pkg::OFIFO_CNT_W-1:0] count
);
  import fdmo_pkg::*;

  rsp_t                   fifo_mem [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr;
  logic [OFIFO_PTR_W-1:0] rd_ptr;
  logic                   pop;

  assign rsp_valid = (count != '0);
  assign rsp_word  = fifo_mem[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OFIFO_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OFIFO_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/frame_diff_morph_open_unit.sv
// Result words pass registers s1, s2, s3, then the output queue.
// Throughput: one word per cycle; the 8-entry output queue with credit for the
// 3 words in flight sets when req_stall rises.
// The opened bit of a pixel comes out 2*width+2 words after that pixel.
// Reset (rst, synchronous): counters, windows and queue clear, geometry 3x3,
// registers 1280 x 720, threshold 32; line buffers keep their contents.
module frame_diff_morph_open_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fdmo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdmo_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  fdmo_pkg::req_t                 req_word,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output fdmo_pkg::rsp_t                 rsp_word
);
  import fdmo_pkg::*;

  logic                         accept;
  logic                         win_adv;
  logic [COL_W-1:0]             win_col;
  logic [THR_W-1:0]             thr;
  stage_t                       s1, s2, s3;
  logic                         mbit, ebit;
  logic [WIN_N*WIN_N-1:0]       mwin, ewin;
  rsp_t                         push_word;
  logic [OFIFO_CNT_W-1:0]       count;

  assign req_stall = (int'(count) + int'(s1.valid) + int'(s2.valid) +
                      int'(s3.valid)) >= OFIFO_DEPTH;
  assign accept    = req_valid && !req_stall;

  fdmo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req_word  (req_word),
    .win_adv   (win_adv),
    .win_col   (win_col),
    .thr       (thr),
    .s1        (s1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
      s3 <= '0;
    end else begin
      s2 <= s1;
      s3 <= s2;
    end
  end

  assign mbit = ({1'b0, s1.diff_value} >= thr);

  fdmo_window u_mask_win (
    .clk    (clk),
    .rst    (rst),
    .adv    (win_adv),
    .col    (win_col),
    .bit_in (mbit),
    .win    (mwin)
  );

  // erosion, border positions forced to 0
  assign ebit = s2.eint && (&mwin);

  fdmo_window u_erode_win (
    .clk    (clk),
    .rst    (rst),
    .adv    (s1.valid && s1.eadv),
    .col    (s1.ecol),
    .bit_in (ebit),
    .win    (ewin)
  );

  // dilation, border positions forced to 0
  always_comb begin
    push_word.diff_value   = s3.diff_value;
    push_word.diff_valid   = s3.diff_valid;
    push_word.opened_bit   = s3.emit && s3.oint && (|ewin);
    push_word.opened_valid = s3.emit;
    push_word.opened_last  = s3.emit && s3.last;
  end

  fdmo_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3.valid),
    .push_word (push_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .count     (count)
  );

endmodule
